>>> hw/rtl/lwq_pkg.sv
// Shared types and constants for the lease-based work queue.
// Holds field widths, request and record codes, controller states and the
// command and status structs between the controller and the datapath.
package lwq_pkg;

	// Widths of the request and response fields.
	localparam int MODE_W   = 3;
	localparam int WORKER_W = 16;
	localparam int INDEX_W  = 10;
	localparam int LEASE_W  = 16;
	localparam int NOW_W    = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 11;

	// Defaults for the top-level parameters.
	localparam int MAX_ITEMS_DEF   = 1024;
	localparam int WORKER_BITS_DEF = 16;
	localparam int TIME_BITS_DEF   = 32;

	// Configuration port.
	localparam int APB_AW = 2;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-1:0] REG_ITEMS_ADDR = 2'd0;

	typedef enum logic [MODE_W-1:0] {
		MODE_CLAIM    = 3'd0,
		MODE_RENEW    = 3'd1,
		MODE_COMPLETE = 3'd2,
		MODE_RELEASE  = 3'd3,
		MODE_PROBE    = 3'd4
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_APPLIED = 2'd0,
		STAT_IGNORED = 2'd1,
		STAT_RANGE   = 2'd2,
		STAT_NONE    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_PENDING = 2'd0,
		ST_CLAIMED = 2'd1,
		ST_DONE    = 2'd2
	} rec_state_t;

	localparam int REC_STATE_W = 2;

	typedef enum logic [2:0] {
		CS_CLEAR,
		CS_IDLE,
		CS_DECODE,
		CS_APPLY,
		CS_SCAN,
		CS_POST
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_step;
		logic load_req;
		logic start_scan;
		logic scan_step;
		logic read_single;
		logic apply_single;
		logic reject;
		logic post;
	} lwq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic req_scan;
		logic req_single;
		logic scan_end;
		logic out_free;
	} lwq_stat_t;

endpackage

>>> hw/rtl/lwq_req_if.sv
// Request channel of the work queue: valid/ready handshake plus payload.
// Depends on lwq_pkg for the field widths.
interface lwq_req_if;
	import lwq_pkg::*;

	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [WORKER_W-1:0] worker_id;
	logic [INDEX_W-1:0]  item_index;
	logic [LEASE_W-1:0]  lease_length;
	logic [NOW_W-1:0]    now_time;

	modport source (
		output valid, mode, worker_id, item_index, lease_length, now_time,
		input  ready
	);
	modport sink (
		input  valid, mode, worker_id, item_index, lease_length, now_time,
		output ready
	);
endinterface

>>> hw/rtl/lwq_rsp_if.sv
// Response channel of the work queue: valid/ready handshake plus payload.
// Depends on lwq_pkg for the field widths.
interface lwq_rsp_if;
	import lwq_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [INDEX_W-1:0]  claimed_index;
	logic                live_lease;
	logic [COUNT_W-1:0]  finished_count;
	logic                all_finished;

	modport source (
		output valid, status, claimed_index, live_lease, finished_count, all_finished,
		input  ready
	);
	modport sink (
		input  valid, status, claimed_index, live_lease, finished_count, all_finished,
		output ready
	);
endinterface

>>> hw/rtl/lease_work_queue_top.sv
// Lease-based work queue. After reset the block sweeps its record memory, one entry per
// cycle, and accepts no request until that pass is done; the items_in_use register can
// be written throughout. Requests are taken one at a time. Renew, complete and release
// go through decode and the record memory read, then the update, then the posting of
// the response. Out-of-range and unknown requests go through decode and post only.
// Claim and probe walk the record memory from the scan hint, one entry per cycle through
// its single read port, and stop at a match or at the end of the range of items_in_use
// entries, capped at MAX_ITEMS, before the response is posted. A response waits in an
// output register, so the next request can be accepted before the previous one is taken.
// Depends on lwq_pkg, lwq_req_if, lwq_rsp_if, lwq_apb_regs, lwq_ctrl and lwq_datapath.
module lease_work_queue_top #(
	parameter int MAX_ITEMS   = lwq_pkg::MAX_ITEMS_DEF,
	parameter int WORKER_BITS = lwq_pkg::WORKER_BITS_DEF,
	parameter int TIME_BITS   = lwq_pkg::TIME_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	lwq_req_if.sink                    req,
	lwq_rsp_if.source                  rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lwq_pkg::APB_AW-1:0] paddr,
	input  logic [lwq_pkg::APB_DW-1:0] pwdata,
	output logic [lwq_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import lwq_pkg::*;

	lwq_cmd_t           cmd;
	lwq_stat_t          st;
	logic [COUNT_W-1:0] items_in_use;
	logic               in_ready;

	lwq_apb_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.items_in_use (items_in_use)
	);

	lwq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	assign req.ready = in_ready;

	lwq_datapath #(
		.MAX_ITEMS   (MAX_ITEMS),
		.WORKER_BITS (WORKER_BITS),
		.TIME_BITS   (TIME_BITS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.st                 (st),
		.mode               (req.mode),
		.worker_id          (req.worker_id),
		.item_index         (req.item_index),
		.lease_length       (req.lease_length),
		.now_time           (req.now_time),
		.items_in_use       (items_in_use),
		.out_valid          (rsp.valid),
		.out_ready          (rsp.ready),
		.out_status         (rsp.status),
		.out_claimed_index  (rsp.claimed_index),
		.out_live_lease     (rsp.live_lease),
		.out_finished_count (rsp.finished_count),
		.out_all_finished   (rsp.all_finished)
	);

endmodule

>>> hw/rtl/lwq_apb_regs.sv
// APB-style configuration register block holding items_in_use.
// Depends on lwq_pkg for the address and data widths.
module lwq_apb_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lwq_pkg::APB_AW-1:0] paddr,
	input  logic [lwq_pkg::APB_DW-1:0] pwdata,
	output logic [lwq_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output logic [lwq_pkg::COUNT_W-1:0] items_in_use
);
	import lwq_pkg::*;

	logic [COUNT_W-1:0] items_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr == REG_ITEMS_ADDR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_q <= '0;
		end else if (wr_en) begin
			items_q <= pwdata[COUNT_W-1:0];
		end
	end

	assign prdata       = (paddr == REG_ITEMS_ADDR) ? APB_DW'(items_q) : '0;
	assign items_in_use = items_q;

endmodule

>>> hw/rtl/lwq_ctrl.sv
// Controller state machine of the work queue: sequences the clearing pass,
// request intake, single-item updates, table scans and result posting.
// Depends on lwq_pkg for the state, command and status types.
module lwq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lwq_pkg::lwq_stat_t st,
	output lwq_pkg::lwq_cmd_t  cmd
);
	import lwq_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			CS_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (st.clear_last) begin
					state_d = CS_IDLE;
				end
			end
			CS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = CS_DECODE;
				end
			end
			CS_DECODE: begin
				priority if (st.req_scan) begin
					cmd.start_scan = 1'b1;
					state_d        = CS_SCAN;
				end else if (st.req_single) begin
					cmd.read_single = 1'b1;
					state_d         = CS_APPLY;
				end else begin
					cmd.reject = 1'b1;
					state_d    = CS_POST;
				end
			end
			CS_APPLY: begin
				cmd.apply_single = 1'b1;
				state_d          = CS_POST;
			end
			CS_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.scan_end) begin
					state_d = CS_POST;
				end
			end
			CS_POST: begin
				if (st.out_free) begin
					cmd.post = 1'b1;
					state_d  = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/lwq_datapath.sv
// Datapath of the work queue: record memory, request and scan registers,
// lease arithmetic, done counter and the response output register.
// Depends on lwq_pkg for codes, widths and the command and status structs.
module lwq_datapath #(
	parameter int MAX_ITEMS   = lwq_pkg::MAX_ITEMS_DEF,
	parameter int WORKER_BITS = lwq_pkg::WORKER_BITS_DEF,
	parameter int TIME_BITS   = lwq_pkg::TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lwq_pkg::lwq_cmd_t            cmd,
	output lwq_pkg::lwq_stat_t           st,
	input  logic [lwq_pkg::MODE_W-1:0]   mode,
	input  logic [lwq_pkg::WORKER_W-1:0] worker_id,
	input  logic [lwq_pkg::INDEX_W-1:0]  item_index,
	input  logic [lwq_pkg::LEASE_W-1:0]  lease_length,
	input  logic [lwq_pkg::NOW_W-1:0]    now_time,
	input  logic [lwq_pkg::COUNT_W-1:0]  items_in_use,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [lwq_pkg::STATUS_W-1:0] out_status,
	output logic [lwq_pkg::INDEX_W-1:0]  out_claimed_index,
	output logic                         out_live_lease,
	output logic [lwq_pkg::COUNT_W-1:0]  out_finished_count,
	output logic                         out_all_finished
);
	import lwq_pkg::*;

	localparam int AW     = $clog2(MAX_ITEMS);
	localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
	localparam int NW     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
	localparam int WB     = WORKER_BITS;
	localparam int TB     = TIME_BITS;
	localparam int REC_W  = REC_STATE_W + WB + TB;
	localparam int SUM_W  = ((TB > LEASE_W) ? TB : LEASE_W) + 1;

	// Record memory: {state, owner, expiry} per item.
	logic [REC_W-1:0] rec_mem [MAX_ITEMS];
	logic [REC_W-1:0] rd_data_q;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [REC_W-1:0] wr_data;

	// Request registers.
	logic [MODE_W-1:0]  req_mode_q;
	logic [WB-1:0]      req_worker_q;
	logic [INDEX_W-1:0] req_idx_q;
	logic [LEASE_W-1:0] req_lease_q;
	logic [TB-1:0]      req_now_q;

	// Control and scan registers.
	logic [AW-1:0] clr_ptr_q;
	logic [NW-1:0] hint_q;
	logic [NW-1:0] scan_ptr_q;
	logic          scan_vld_q;
	logic [NW-1:0] data_idx_q;
	logic          seen_q;
	logic [NW-1:0] first_q;
	logic [COUNT_W-1:0] done_total_q;

	// Result and output registers.
	logic [STATUS_W-1:0] res_status_q;
	logic [INDEX_W-1:0]  res_claimed_q;
	logic                res_live_q;
	logic                out_vld_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [INDEX_W-1:0]  out_claimed_q;
	logic                out_live_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic                out_all_q;

	logic [NW-1:0]      n_items;
	logic               mode_single;
	logic               idx_out;
	logic               is_claim;
	logic [REC_STATE_W-1:0] rd_state;
	logic [WB-1:0]      rd_worker;
	logic [TB-1:0]      rd_expiry;
	logic [SUM_W-1:0]   lease_sum;
	logic [TB-1:0]      lease_end;
	logic               owner_match;
	logic               scan_more;
	logic               data_unfinished;
	logic               hit_claim;
	logic               hit_probe;
	logic               scan_hit;
	logic               scan_end;
	logic [NW-1:0]      hint_new;
	logic               sgl_we;
	logic [REC_W-1:0]   sgl_data;
	logic [STATUS_W-1:0] sgl_status;
	logic               sgl_inc;

	// Effective table size is the configured count capped at the table depth.
	assign n_items = (NW'(items_in_use) < NW'(MAX_ITEMS)) ? NW'(items_in_use) : NW'(MAX_ITEMS);

	assign mode_single = (req_mode_q == MODE_RENEW) || (req_mode_q == MODE_COMPLETE) ||
		(req_mode_q == MODE_RELEASE);
	assign idx_out  = NW'(req_idx_q) >= n_items;
	assign is_claim = (req_mode_q == MODE_CLAIM);

	assign rd_state  = rd_data_q[REC_W-1 -: REC_STATE_W];
	assign rd_worker = rd_data_q[TB +: WB];
	assign rd_expiry = rd_data_q[TB-1:0];

	// The expiry saturates at the largest time value instead of wrapping.
	assign lease_sum = SUM_W'(req_now_q) + SUM_W'(req_lease_q);
	assign lease_end = ((lease_sum >> TB) != '0) ? {TB{1'b1}} : lease_sum[TB-1:0];

	assign owner_match = (rd_state == ST_CLAIMED) && (rd_worker == req_worker_q);

	// Scan: a read is issued for scan_ptr while the previous entry is evaluated.
	assign scan_more       = scan_ptr_q < n_items;
	assign data_unfinished = scan_vld_q && (rd_state != ST_DONE);
	assign hit_claim = scan_vld_q && ((rd_state == ST_PENDING) ||
		((rd_state == ST_CLAIMED) && (rd_expiry <= req_now_q)));
	assign hit_probe = scan_vld_q && (rd_state == ST_CLAIMED) && (rd_expiry > req_now_q);
	assign scan_hit  = is_claim ? hit_claim : hit_probe;
	assign scan_end  = scan_hit || (!scan_vld_q && !scan_more);
	assign hint_new  = seen_q ? first_q : (data_unfinished ? data_idx_q : hint_q);

	// Single-item update for renew, complete and release.
	always_comb begin
		sgl_we     = 1'b0;
		sgl_data   = '0;
		sgl_status = STAT_IGNORED;
		sgl_inc    = 1'b0;
		unique case (req_mode_q)
			MODE_RENEW: begin
				if (owner_match) begin
					sgl_we     = 1'b1;
					sgl_data   = {ST_CLAIMED, rd_worker, lease_end};
					sgl_status = STAT_APPLIED;
				end
			end
			MODE_COMPLETE: begin
				if ((rd_state != ST_DONE) &&
					!((rd_state == ST_CLAIMED) && (rd_worker != req_worker_q))) begin
					sgl_we     = 1'b1;
					sgl_data   = {ST_DONE, req_worker_q, {TB{1'b0}}};
					sgl_status = STAT_APPLIED;
					sgl_inc    = 1'b1;
				end
			end
			MODE_RELEASE: begin
				if (owner_match) begin
					sgl_we     = 1'b1;
					sgl_data   = {ST_PENDING, {WB{1'b0}}, {TB{1'b0}}};
					sgl_status = STAT_APPLIED;
				end
			end
			default: begin
				sgl_we = 1'b0;
			end
		endcase
	end

	// Memory port selection.
	always_comb begin
		rd_en   = cmd.read_single || (cmd.scan_step && !scan_end && scan_more);
		rd_addr = cmd.read_single ? AW'(req_idx_q) : scan_ptr_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = clr_ptr_q;
		wr_data = '0;
		priority if (cmd.clear_step) begin
			wr_en = 1'b1;
		end else if (cmd.apply_single) begin
			wr_en   = sgl_we;
			wr_addr = AW'(req_idx_q);
			wr_data = sgl_data;
		end else if (cmd.scan_step && is_claim && hit_claim) begin
			wr_en   = 1'b1;
			wr_addr = data_idx_q[AW-1:0];
			wr_data = {ST_CLAIMED, req_worker_q, lease_end};
		end else begin
			wr_en = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rec_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= rec_mem[rd_addr];
		end
	end

	// Request payload.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_mode_q   <= mode;
			req_worker_q <= WB'(worker_id);
			req_idx_q    <= item_index;
			req_lease_q  <= lease_length;
			req_now_q    <= TB'(now_time);
		end
	end

	// Clearing pass, scan hint, scan control and done counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_ptr_q    <= '0;
			hint_q       <= '0;
			scan_ptr_q   <= '0;
			scan_vld_q   <= 1'b0;
			seen_q       <= 1'b0;
			done_total_q <= '0;
		end else begin
			if (cmd.clear_step) begin
				clr_ptr_q <= clr_ptr_q + AW'(1);
			end
			if (cmd.start_scan) begin
				scan_ptr_q <= hint_q;
				scan_vld_q <= 1'b0;
				seen_q     <= 1'b0;
			end
			if (cmd.scan_step) begin
				if (!scan_end) begin
					scan_vld_q <= scan_more;
					if (scan_more) begin
						scan_ptr_q <= scan_ptr_q + NW'(1);
					end
				end
				if (data_unfinished && !seen_q) begin
					seen_q <= 1'b1;
				end
				if (scan_end && is_claim) begin
					hint_q <= hint_new;
				end
			end
			if (cmd.apply_single && sgl_inc) begin
				done_total_q <= done_total_q + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && !scan_end && scan_more) begin
			data_idx_q <= scan_ptr_q;
		end
		if (cmd.scan_step && data_unfinished && !seen_q) begin
			first_q <= data_idx_q;
		end
	end

	// Result of the request in flight.
	always_ff @(posedge clk) begin
		if (cmd.reject) begin
			res_status_q  <= mode_single ? STAT_RANGE : STAT_IGNORED;
			res_claimed_q <= '0;
			res_live_q    <= 1'b0;
		end else if (cmd.apply_single) begin
			res_status_q  <= sgl_status;
			res_claimed_q <= '0;
			res_live_q    <= 1'b0;
		end else if (cmd.scan_step && scan_end) begin
			if (is_claim) begin
				res_status_q  <= hit_claim ? STAT_APPLIED : STAT_NONE;
				res_claimed_q <= hit_claim ? INDEX_W'(data_idx_q) : '0;
				res_live_q    <= 1'b0;
			end else begin
				res_status_q  <= STAT_APPLIED;
				res_claimed_q <= '0;
				res_live_q    <= hit_probe;
			end
		end
	end

	// Output register lets the next request start while a response waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.post) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.post) begin
			out_status_q  <= res_status_q;
			out_claimed_q <= res_claimed_q;
			out_live_q    <= res_live_q;
			out_count_q   <= done_total_q;
			out_all_q     <= done_total_q >= items_in_use;
		end
	end

	assign st.clear_last = (clr_ptr_q == AW'(MAX_ITEMS - 1));
	assign st.req_scan   = (req_mode_q == MODE_CLAIM) || (req_mode_q == MODE_PROBE);
	assign st.req_single = mode_single && !idx_out;
	assign st.scan_end   = scan_end;
	assign st.out_free   = !out_vld_q || out_ready;

	assign out_valid          = out_vld_q;
	assign out_status         = out_status_q;
	assign out_claimed_index  = out_claimed_q;
	assign out_live_lease     = out_live_q;
	assign out_finished_count = out_count_q;
	assign out_all_finished   = out_all_q;

endmodule
